// File: rtl/cht_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cht_pkg - shared types for the chained hash table engine
// Field widths, action and status codes, controller states and the
// transaction payload structs of both channels.
// ---------------------------------------------------------------------------
package cht_pkg;

   localparam int ACT_W  = 2;
   localparam int KEY_W  = 31;
   localparam int VAL_W  = 16;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 9;

   typedef enum logic [ACT_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_SEARCH = 2'd1,
      ACT_REMOVE = 2'd2
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_HIT  = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_HEAD,
      ST_HEAD_WAIT,
      ST_WALK,
      ST_REC,
      ST_FINISH,
      ST_LINK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [VAL_W-1:0]  value_res;
   } rsp_type;

endpackage

// File: rtl/chained_hash_table_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chained_hash_table_engine - hash table with separately chained records
// Inserts, searches and removes keys in a pool of chained records.
//
// Usage:
//  - req_valid/req_ready carry one transaction: action, key and value.
//  - rsp_valid/rsp_ready return one transaction per request: status and
//    the stored value of a found or removed record.
//  - csr_wr_en/csr_wr_data set the bucket count; write only while idle.
//  - One request in flight. Its result passes through the modulo unit, the
//    head read, one read per record walked, the end of the walk and the
//    output register; an insert that misses adds a finish step to store the
//    record and, when it appends to a non-empty chain, a link step.
//  - After reset the bucket head RAM is cleared, one entry a cycle;
//    req_ready stays low during that pass.
//  - A result waits in the output register while rsp_ready is low; the
//    next request is accepted meanwhile and holds in its final state until
//    the register frees.
// ---------------------------------------------------------------------------
module chained_hash_table_engine #(
   parameter int BUCKETS = 256,
   parameter int RECORDS = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  cht_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cht_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [cht_pkg::CNT_W-1:0] csr_wr_data
);
   import cht_pkg::*;

   localparam int AW = $clog2(RECORDS);
   localparam int LW = AW + 1;
   localparam int BW = $clog2(BUCKETS);
   localparam logic [LW-1:0] NULL_LINK = '1;

   typedef struct packed {
      logic             live;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      logic [LW-1:0]    next;
   } rec_type;

   localparam int RW = $bits(rec_type);

   state_type        state_ff, state_in;
   logic [ACT_W-1:0] act_ff, act_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [BW-1:0]    bkt_ff, bkt_in;
   logic [LW-1:0]    p_ff, p_in;
   logic [LW-1:0]    steps_ff, steps_in;
   logic [LW-1:0]    hole_ff, hole_in;
   logic [LW-1:0]    hole_next_ff, hole_next_in;
   logic [LW-1:0]    tail_ff, tail_in;
   rec_type          tail_rec_ff, tail_rec_in;
   logic [LW-1:0]    used_ff, used_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [VAL_W-1:0] res_ff, res_in;
   logic [BW-1:0]    clr_ff, clr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic [CNT_W-1:0] eff_count;
   logic             mod_done;
   logic [CNT_W-1:0] mod_rem;
   logic             walk_go, hole_ok, tail_ok, pool_ok;
   logic             is_insert, hit_key, found, rsp_free;
   rec_type          rec_rd, rec_wr_data;
   logic             rec_wr_en, rec_rd_en;
   logic [AW-1:0]    rec_wr_addr;
   logic             head_wr_en, head_rd_en;
   logic [BW-1:0]    head_wr_addr;
   logic [LW-1:0]    head_wr_data, head_rd_data;
   logic [RW-1:0]    rec_rd_raw;

   // clamp the bucket count into 1..BUCKETS
   always_comb begin
      if (count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (32'(count_ff) > BUCKETS) begin
         eff_count = CNT_W'(BUCKETS);
      end else begin
         eff_count = count_ff;
      end
   end

   cht_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (req_data.key),
      .divisor   (eff_count),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   cht_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_en   (head_rd_en),
      .rd_addr (bkt_ff),
      .rd_data (head_rd_data)
   );

   cht_ram #(.WIDTH(RW), .DEPTH(RECORDS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .rd_en   (rec_rd_en),
      .rd_addr (p_ff[AW-1:0]),
      .rd_data (rec_rd_raw)
   );

   // walk decisions
   assign rec_rd    = rec_rd_raw;
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign is_insert = (act_ff == ACT_INSERT);
   assign walk_go   = (p_ff < LW'(RECORDS)) && (steps_ff < LW'(RECORDS));
   assign hole_ok   = (hole_ff < LW'(RECORDS));
   assign tail_ok   = (tail_ff < LW'(RECORDS));
   assign pool_ok   = (used_ff < LW'(RECORDS));
   assign hit_key   = (rec_rd.key == key_ff);
   assign found     = hit_key && rec_rd.live;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == BW'(BUCKETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACT_INSERT || req_data.action == ACT_SEARCH ||
                   req_data.action == ACT_REMOVE) begin
                  state_in = ST_MOD;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_MOD: begin
            if (mod_done) state_in = ST_HEAD;
         end
         ST_HEAD:      state_in = ST_HEAD_WAIT;
         ST_HEAD_WAIT: state_in = ST_WALK;
         ST_WALK: begin
            if (walk_go) state_in = ST_REC;
            else if (is_insert) state_in = ST_FINISH;
            else state_in = ST_RESP;
         end
         ST_REC: begin
            if ((is_insert && hit_key) || (!is_insert && found)) state_in = ST_RESP;
            else state_in = ST_WALK;
         end
         ST_FINISH: begin
            if (!hole_ok && pool_ok && tail_ok) state_in = ST_LINK;
            else state_in = ST_RESP;
         end
         ST_LINK: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath, memory controls and outputs
   always_comb begin
      act_in       = act_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      bkt_in       = bkt_ff;
      p_in         = p_ff;
      steps_in     = steps_ff;
      hole_in      = hole_ff;
      hole_next_in = hole_next_ff;
      tail_in      = tail_ff;
      tail_rec_in  = tail_rec_ff;
      used_in      = used_ff;
      status_in    = status_ff;
      res_in       = res_ff;
      clr_in       = clr_ff;
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      head_wr_en   = 1'b0;
      head_wr_addr = bkt_ff;
      head_wr_data = used_ff;
      head_rd_en   = 1'b0;
      rec_rd_en    = 1'b0;
      rec_wr_en    = 1'b0;
      rec_wr_addr  = used_ff[AW-1:0];
      rec_wr_data  = '{live: 1'b1, key: key_ff, value: val_ff, next: NULL_LINK};
      unique case (state_ff)
         ST_CLEAR: begin
            head_wr_en   = 1'b1;
            head_wr_addr = clr_ff;
            head_wr_data = NULL_LINK;
            clr_in       = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            act_in    = req_data.action;
            key_in    = req_data.key;
            val_in    = req_data.value;
            steps_in  = '0;
            hole_in   = NULL_LINK;
            tail_in   = NULL_LINK;
            status_in = STAT_MISS;
            res_in    = '0;
         end
         ST_MOD: begin
            bkt_in = BW'(mod_rem);
         end
         ST_HEAD: begin
            head_rd_en = 1'b1;
         end
         ST_HEAD_WAIT: begin
            p_in = head_rd_data;
         end
         ST_WALK: begin
            rec_rd_en = walk_go;
         end
         ST_REC: begin
            // compare the record, then update it or advance down the chain
            rec_wr_addr = p_ff[AW-1:0];
            if (is_insert && hit_key) begin
               rec_wr_en   = 1'b1;
               rec_wr_data = '{live: 1'b1, key: rec_rd.key, value: val_ff, next: rec_rd.next};
               status_in   = STAT_HIT;
            end else if (!is_insert && found) begin
               status_in = STAT_HIT;
               res_in    = rec_rd.value;
               if (act_ff == ACT_REMOVE) begin
                  rec_wr_en   = 1'b1;
                  rec_wr_data = '{live: 1'b0, key: rec_rd.key, value: rec_rd.value,
                                  next: rec_rd.next};
               end
            end else begin
               if (is_insert) begin
                  if (!rec_rd.live && !hole_ok) begin
                     hole_in      = p_ff;
                     hole_next_in = rec_rd.next;
                  end
                  tail_in     = p_ff;
                  tail_rec_in = rec_rd;
               end
               p_in     = rec_rd.next;
               steps_in = steps_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            // reuse a removed record, append a fresh one, or drop
            if (hole_ok) begin
               rec_wr_en   = 1'b1;
               rec_wr_addr = hole_ff[AW-1:0];
               rec_wr_data = '{live: 1'b1, key: key_ff, value: val_ff, next: hole_next_ff};
            end else if (pool_ok) begin
               rec_wr_en  = 1'b1;
               used_in    = used_ff + 1'b1;
               head_wr_en = !tail_ok;
            end else begin
               status_in = STAT_FULL;
            end
         end
         ST_LINK: begin
            rec_wr_en   = 1'b1;
            rec_wr_addr = tail_ff[AW-1:0];
            rec_wr_data = '{live: tail_rec_ff.live, key: tail_rec_ff.key,
                            value: tail_rec_ff.value, next: used_ff - 1'b1};
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = status_ff;
               rsp_in.value_res = res_ff;
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         count_ff     <= CNT_W'(256);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff       <= act_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      bkt_ff       <= bkt_in;
      p_ff         <= p_in;
      steps_ff     <= steps_in;
      hole_ff      <= hole_in;
      hole_next_ff <= hole_next_in;
      tail_ff      <= tail_in;
      tail_rec_ff  <= tail_rec_in;
      status_ff    <= status_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/cht_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cht_ram - generic simple dual port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cht_mod.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cht_mod - iterative key modulo unit
// Restoring remainder, one key bit per cycle, done pulses after the last bit.
// ---------------------------------------------------------------------------
module cht_mod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [cht_pkg::KEY_W-1:0] dividend,
   input  logic [cht_pkg::CNT_W-1:0] divisor,
   output logic                      done,
   output logic [cht_pkg::CNT_W-1:0] remainder
);
   import cht_pkg::*;

   localparam int CW = $clog2(KEY_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [KEY_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W:0]   shifted;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff, quo_ff[KEY_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[KEY_W-2:0], 1'b0};
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = CNT_W'(shifted - {1'b0, div_ff});
         end else begin
            rem_in = shifted[CNT_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(KEY_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: sim/tb_chained_hash_table_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_chained_hash_table_engine - self-checking bench for the hash engine
// Sends insert, search, remove and unused-action transactions under several
// bucket counts and idle patterns. A scoreboard keeps its own copy of the
// table, predicts each response and compares it field by field. The run ends
// by filling the record pool until inserts are dropped.
// ---------------------------------------------------------------------------
module tb_chained_hash_table_engine;
   import cht_pkg::*;

   localparam int            NUM_BUCKETS = 256;
   localparam int            NUM_RECORDS = 1024;
   localparam logic [10:0]   NULL_LINK   = 11'h7FF;
   localparam logic [1:0]    ACT_UNUSED  = 2'd3;
   localparam int            CYCLE_LIMIT = 1000000;
   localparam logic [30:0]   KEY_MAX     = 31'h7FFFFFFF;

   // Table predictor and response checker
   class cht_scoreboard;
      int unsigned  bucket_count;
      logic [10:0]  heads[NUM_BUCKETS];
      logic [30:0]  keys[NUM_RECORDS];
      logic [15:0]  vals[NUM_RECORDS];
      logic [10:0]  links[NUM_RECORDS];
      bit           live[NUM_RECORDS];
      int unsigned  records_used;
      rsp_type      expected_q[$];
      int           errors;
      int           checked;

      function new();
         bucket_count = 256;
         foreach (heads[i]) heads[i] = NULL_LINK;
         records_used = 0;
         errors       = 0;
         checked      = 0;
      endfunction

      // Walk the chain of the request's bucket and apply the action
      function void note_request(req_type r);
         int unsigned n;
         int unsigned b;
         int unsigned steps;
         logic [10:0] p;
         logic [10:0] tail;
         logic [10:0] hole;
         bit          done;
         rsp_type     e;
         n = bucket_count;
         if (n == 0) n = 1;
         if (n > NUM_BUCKETS) n = NUM_BUCKETS;
         b = int'(r.key) % n;
         p = heads[b];
         steps = 0;
         tail = NULL_LINK;
         hole = NULL_LINK;
         done = 0;
         e.status = STAT_MISS;
         e.value_res = '0;
         case (r.action)
            ACT_SEARCH, ACT_REMOVE: begin
               while (p < NUM_RECORDS && steps < NUM_RECORDS) begin
                  if (keys[p] == r.key && live[p]) begin
                     e.status = STAT_HIT;
                     e.value_res = vals[p];
                     if (r.action == ACT_REMOVE) live[p] = 0;
                     break;
                  end
                  p = links[p];
                  steps++;
               end
            end
            ACT_INSERT: begin
               while (p < NUM_RECORDS && steps < NUM_RECORDS) begin
                  if (keys[p] == r.key) begin
                     vals[p] = r.value;
                     live[p] = 1;
                     e.status = STAT_HIT;
                     done = 1;
                     break;
                  end
                  if (!live[p] && hole >= NUM_RECORDS) hole = p;
                  tail = p;
                  p = links[p];
                  steps++;
               end
               if (!done) begin
                  if (hole < NUM_RECORDS) begin
                     keys[hole] = r.key;
                     vals[hole] = r.value;
                     live[hole] = 1;
                  end else if (records_used < NUM_RECORDS) begin
                     keys[records_used]  = r.key;
                     vals[records_used]  = r.value;
                     links[records_used] = NULL_LINK;
                     live[records_used]  = 1;
                     if (tail < NUM_RECORDS) links[tail] = 11'(records_used);
                     else heads[b] = 11'(records_used);
                     records_used++;
                  end else begin
                     e.status = STAT_FULL;
                  end
               end
            end
            default: ;
         endcase
         expected_q.push_back(e);
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask

      // Compare one response with the oldest prediction
      task check_response(rsp_type r);
         rsp_type e;
         checked++;
         if (expected_q.size() == 0) begin
            report($sformatf("response %0d with nothing pending", checked));
         end else begin
            e = expected_q.pop_front();
            if (r.status !== e.status)
               report($sformatf("response %0d status %0d, want %0d",
                                checked, r.status, e.status));
            if (r.value_res !== e.value_res)
               report($sformatf("response %0d value_res %h, want %h",
                                checked, r.value_res, e.value_res));
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_wr_en;
   logic [CNT_W-1:0]    csr_wr_data;

   cht_scoreboard       sb;
   int                  send_idle_pct;
   int                  recv_idle_pct;
   int                  items_sent;
   int                  cycles;

   chained_hash_table_engine i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Bound the run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("chained_hash_table_engine regression: fail");
         $finish;
      end
   end

   // Stall the response channel at random
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Check each accepted response transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // Present one transaction and hold it until accepted
   task send_request(input logic [1:0] action, input logic [30:0] key,
                     input logic [15:0] value);
      req_type r;
      r.action = action;
      r.key    = key;
      r.value  = value;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_data  = r;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold off until every pending response has come back
   task drain;
      req_valid = 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
   endtask

   task write_bucket_count(input logic [CNT_W-1:0] count);
      drain();
      csr_wr_data = count;
      csr_wr_en   = 1;
      @(negedge clock);
      csr_wr_en   = 0;
      sb.bucket_count = count;
   endtask

   // Mostly a small key set so chains collide, with some full-range keys
   function automatic logic [30:0] pick_key();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 85) return 31'($urandom_range(0, 63));
      if (sel < 95) return 31'($urandom);
      return KEY_MAX - 31'($urandom_range(0, 3));
   endfunction

   function automatic logic [1:0] pick_action();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 45) return ACT_INSERT;
      if (sel < 75) return ACT_SEARCH;
      if (sel < 95) return ACT_REMOVE;
      return ACT_UNUSED;
   endfunction

   initial begin
      int                counts[6];
      int                guard;
      logic [30:0]       fill_key;
      counts = '{2, 0, 511, 7, 100, 256};
      sb = new();
      cycles = 0;
      items_sent = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      rsp_ready = 0;
      csr_wr_en = 0;
      csr_wr_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: empty table, key extremes, tail append, holes, revival
      send_request(ACT_SEARCH, 31'd0, 16'h0000);
      send_request(ACT_INSERT, 31'd0, 16'h0000);
      send_request(ACT_INSERT, KEY_MAX, 16'hFFFF);
      send_request(ACT_SEARCH, 31'd0, 16'hFFFF);
      send_request(ACT_SEARCH, KEY_MAX, 16'h0000);
      send_request(ACT_INSERT, 31'd256, 16'h1234);
      send_request(ACT_REMOVE, 31'd0, 16'h0000);
      send_request(ACT_SEARCH, 31'd0, 16'h0000);
      send_request(ACT_INSERT, 31'd512, 16'hA5A5);
      send_request(ACT_INSERT, 31'd0, 16'h5A5A);
      send_request(ACT_INSERT, 31'd256, 16'h0101);
      send_request(ACT_REMOVE, 31'd256, 16'h0000);
      send_request(ACT_REMOVE, 31'd256, 16'h0000);
      send_request(ACT_INSERT, 31'd256, 16'h8000);
      send_request(ACT_SEARCH, 31'd256, 16'h0000);
      send_request(ACT_REMOVE, 31'd768, 16'h0000);
      send_request(ACT_UNUSED, KEY_MAX, 16'hFFFF);
      send_request(ACT_REMOVE, KEY_MAX, 16'h0000);
      send_request(ACT_SEARCH, KEY_MAX, 16'h0000);

      // Random phases across bucket counts and idle patterns
      for (int ph = 0; ph < 6; ph++) begin
         write_bucket_count(CNT_W'(counts[ph]));
         if (ph < 2) begin
            send_idle_pct = 35;
            recv_idle_pct = 88;
         end else if (ph < 4) begin
            send_idle_pct = 88;
            recv_idle_pct = 35;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int i = 0; i < 100; i++) begin
            send_request(pick_action(), pick_key(), 16'($urandom_range(0, 65535)));
         end
      end

      // Fill the pool with fresh keys, then overflow it
      write_bucket_count(CNT_W'(256));
      guard = 0;
      while (sb.records_used < NUM_RECORDS && guard < 1200) begin
         fill_key = 31'h4000_0000 + 31'(guard);
         send_request(ACT_INSERT, fill_key, 16'($urandom));
         guard++;
      end
      for (int i = 0; i < 4; i++)
         send_request(ACT_INSERT, 31'h5000_0000 + 31'(i), 16'($urandom));
      send_request(ACT_INSERT, 31'h4000_0000, 16'h7777);
      send_request(ACT_SEARCH, 31'h4000_0000, 16'h0000);
      send_request(ACT_SEARCH, 31'h5000_0000, 16'h0000);

      drain();
      repeat (100) @(posedge clock);
      $display("sent %0d transactions, checked %0d responses, %0d records used",
               items_sent, sb.checked, sb.records_used);
      $display("bucket counts 256, 2, 0, 511, 7, 100 with idle on each side");
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("chained_hash_table_engine regression: pass");
      end else begin
         $display("%0d mismatches, %0d responses missing", sb.errors,
                  sb.expected_q.size());
         $display("chained_hash_table_engine regression: fail");
      end
      $finish;
   end

endmodule
